// File: hdl/indexed_list_insert_erase_top_defines.svh
// assertion macros used by the port-level checker file
`ifndef INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH

// property checked while reset is released
`define ILIE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define ILIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ilie_pkg.sv
// shared types and constants of the indexed list
`default_nettype none

package ilie_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = 4;   // match position field
  localparam int unsigned CNT_W  = 5;   // count, position and capacity fields
  localparam int unsigned CAP_RESET = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              ers;
    logic [CNT_W-1:0]  pos;
    logic [ELEM_W-1:0] val;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/ilie_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares against the key
`default_nettype none

module ilie_cell (
  input  wire logic                       clk_i,
  input  wire ilie_pkg::cell_cmd_t        cmd_i,
  input  wire logic [ilie_pkg::IDX_W-1:0] idx_i,
  input  wire logic [ilie_pkg::CNT_W-1:0] count_i,
  input  wire logic [ilie_pkg::ELEM_W-1:0] left_i,
  input  wire logic [ilie_pkg::ELEM_W-1:0] right_i,
  output logic [ilie_pkg::ELEM_W-1:0]     entry_o,
  output logic                            hit_o,
  output logic [ilie_pkg::ELEM_W-1:0]     rd_o
);
  import ilie_pkg::*;

  logic [ELEM_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0]  idx_ext;
  logic              valid;

  assign idx_ext = {{(CNT_W-IDX_W){1'b0}}, idx_i};
  assign valid   = idx_ext < count_i;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_ext == cmd_i.pos) begin
        entry_d = cmd_i.val;
      end else if (idx_ext > cmd_i.pos) begin
        entry_d = left_i;
      end
    end else if (cmd_i.ers && (idx_ext >= cmd_i.pos)) begin
      entry_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = valid && (entry_q == cmd_i.val);
  assign rd_o    = (idx_ext == cmd_i.pos) ? entry_q : '0;

endmodule

`default_nettype wire

// File: hdl/indexed_list_insert_erase_top.sv
// top level of the indexed list: command decode, cell row and result register
// result: registered in the output register when its command item is accepted
// throughput: one command item per cycle; every cell shifts and compares in parallel
// a waiting result blocks new items only while the downstream side holds tready low
// reset (rst_ni low, asynchronous): count 0, capacity 16, no result pending
// entries are not reset; only positions below the count are ever read
`default_nettype none

module indexed_list_insert_erase_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: capacity write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,    // capacity
  // command item stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [39:0] s_tdata_i,     // position[4:0], value[36:5], zero fill
  input  wire logic [1:0]  s_tuser_i,     // cmd
  // result item stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [47:0]      m_tdata_o,     // read_value[31:0], found[32],
                                          // match_position[36:33], count[41:37], zero fill
  output logic [1:0]       m_tuser_o      // status
);
  import ilie_pkg::*;

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q;
  logic             out_vld_q;

  // result payload register
  logic [1:0]        status_q, status_d;
  logic [ELEM_W-1:0] rdval_q, rdval_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  mpos_q, mpos_d;
  logic [CNT_W-1:0]  cnt_out_q;

  // unpacked command fields
  cmd_e              cmd;
  logic [CNT_W-1:0]  pos;
  logic [ELEM_W-1:0] val;
  logic              accept;
  logic [CNT_W-1:0]  limit;

  cell_cmd_t         cell_cmd;
  logic [ELEM_W-1:0] entry_w [DEPTH];
  logic [ELEM_W-1:0] rd_w    [DEPTH];
  logic [DEPTH-1:0]  hit_w;
  logic [ELEM_W-1:0] rd_any;
  logic [IDX_W-1:0]  first_hit;

  assign cmd = cmd_e'(s_tuser_i);
  assign pos = s_tdata_i[CNT_W-1:0];
  assign val = s_tdata_i[CNT_W +: ELEM_W];

  // output register parts the two sides; a new item enters as the old result leaves
  assign s_tready_o  = !out_vld_q || m_tready_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;

  // effective limit is the smaller of capacity and the built depth
  assign limit = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;

  // row of cells, each sees its left and right neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = entry_w[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner_r
      assign right_v = entry_w[g+1];
    end

    ilie_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .idx_i   (IDX_W'(g)),
      .count_i (count_q),
      .left_i  (left_v),
      .right_i (right_v),
      .entry_o (entry_w[g]),
      .hit_o   (hit_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  // only the addressed cell drives a nonzero read word
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  // lowest matching position
  always_comb begin
    first_hit = '0;
    for (int i = DEPTH-1; i >= 0; i--) begin
      if (hit_w[i]) begin
        first_hit = IDX_W'(i);
      end
    end
  end

  // command decode, status and next count
  always_comb begin
    status_d     = ST_OK;
    rdval_d      = '0;
    found_d      = 1'b0;
    mpos_d       = '0;
    count_d      = count_q;
    cell_cmd.ins = 1'b0;
    cell_cmd.ers = 1'b0;
    cell_cmd.pos = pos;
    cell_cmd.val = val;
    unique case (cmd)
      CMD_INSERT: begin
        if (pos > count_q) begin
          status_d = ST_RANGE;
        end else if (count_q >= limit) begin
          status_d = ST_FULL;
        end else begin
          cell_cmd.ins = accept;
          count_d      = count_q + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          cell_cmd.ers = accept;
          count_d      = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          rdval_d = rd_any;
        end
      end
      CMD_SEARCH: begin
        found_d = |hit_w;
        mpos_d  = found_d ? first_hit : '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cap_q     <= CNT_W'(CAP_RESET);
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rdval_q   <= rdval_d;
      found_q   <= found_d;
      mpos_q    <= mpos_d;
      cnt_out_q <= count_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = status_q;
  assign m_tdata_o  = {6'b0, cnt_out_q, mpos_q, found_q, rdval_q};

endmodule

`default_nettype wire

// File: hdl/indexed_list_insert_erase_top_chk.sv
// port-level checker for the indexed list, bound to the top level
`default_nettype none

`include "indexed_list_insert_erase_top_defines.svh"

module indexed_list_insert_erase_top_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [47:0] m_tdata_o,
  input wire logic [1:0]  m_tuser_o
);
  import ilie_pkg::*;

  `ILIE_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_tvalid_o, "result valid in reset")

  `ILIE_ASSERT(a_result_held, clk_i, rst_ni, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o), "stalled result changed")

  `ILIE_ASSERT(a_stall_only_on_result, clk_i, rst_ni, !s_tready_o |-> m_tvalid_o && !m_tready_i, "input stalled without a waiting result")

  `ILIE_ASSERT(a_empty_count, clk_i, rst_ni, m_tvalid_o && (m_tuser_o == ST_EMPTY) |-> (m_tdata_o[41:37] == 5'd0), "empty status with nonzero count")

  `ILIE_ASSERT(a_match_below_count, clk_i, rst_ni, m_tvalid_o && m_tdata_o[32] |-> ({1'b0, m_tdata_o[36:33]} < m_tdata_o[41:37]) && (m_tuser_o == ST_OK), "match outside the list")

endmodule

bind indexed_list_insert_erase_top indexed_list_insert_erase_top_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

`default_nettype wire
